// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the tilt angle core.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/atr_pkg.sv =====
// Package for the tilt angle core: widths, CORDIC angle table, FSM states.
// No dependencies.
`default_nettype none
package atr_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int RUN_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W = 5;
  localparam int SUMSQ_W = 32;
  localparam int ROOT_W = 31;    // isqrt of a 62-bit radicand
  localparam int CW = 36;        // CORDIC x/y width
  localparam int ZW = 32;        // angle accumulator, Q2.30
  localparam int ROLL_LIMIT = 23040;
  localparam int ROLL_SCALE = 57;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_CORDIC, ST_SCALE, ST_OUT
  } atr_state_t;

  function automatic logic [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:  atan_q30 = 32'd843314856;
      5'd1:  atan_q30 = 32'd497837829;
      5'd2:  atan_q30 = 32'd263043836;
      5'd3:  atan_q30 = 32'd133525158;
      5'd4:  atan_q30 = 32'd67021686;
      5'd5:  atan_q30 = 32'd33543515;
      5'd6:  atan_q30 = 32'd16775850;
      5'd7:  atan_q30 = 32'd8388437;
      5'd8:  atan_q30 = 32'd4194282;
      5'd9:  atan_q30 = 32'd2097149;
      5'd10: atan_q30 = 32'd1048575;
      5'd11: atan_q30 = 32'd524287;
      5'd12: atan_q30 = 32'd262143;
      5'd13: atan_q30 = 32'd131071;
      5'd14: atan_q30 = 32'd65535;
      5'd15: atan_q30 = 32'd32767;
      5'd16: atan_q30 = 32'd16383;
      5'd17: atan_q30 = 32'd8191;
      5'd18: atan_q30 = 32'd4095;
      5'd19: atan_q30 = 32'd2047;
      5'd20: atan_q30 = 32'd1023;
      5'd21: atan_q30 = 32'd511;
      5'd22: atan_q30 = 32'd255;
      5'd23: atan_q30 = 32'd127;
      default: atan_q30 = '0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/atr_isqrt.sv =====
// Digit-serial integer square root, one result bit per cycle.
// Depends on atr_pkg.
`default_nettype none
module atr_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [atr_pkg::SUMSQ_W-1:0] sumsq,
  output logic                             done,
  output logic [atr_pkg::ROOT_W-1:0]       root
);
  import atr_pkg::*;
  // radicand is sumsq << 30: 62 bits, 31 digit pairs
  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+1:0]   rem;
  logic [4:0]          cnt;
  logic                busy;
  logic [ROOT_W+1:0]   trial;
  logic [ROOT_W+1:0]   rem_sh;

  assign rem_sh = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(ROOT_W - 1);
        rad  <= {sumsq, 30'd0};
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[2*ROOT_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/accel_tilt_roll_angle_core.sv =====
// Top level of the accelerometer roll angle core: root, CORDIC, scaling.
// Depends on atr_pkg, atr_isqrt and assert_macros.svh.
//
// Usage:
//   s_axis carries one sample per item: tdata = {accel_z, accel_y, accel_x}
//   (x in bits 15:0). m_axis returns one result per sample: tdata = roll_q8,
//   tuser = held. Roll is atan2(y, sqrt(x^2+z^2)) * 57 in signed Q8.8,
//   rounded and saturated to +/-23040.
//   An all-zero sample shows its result in the cycle after it is
//   taken, with the held angle and held=1. Other samples are squared, then
//   go through the bit-serial square root (31 result bits, one a cycle), 16
//   CORDIC iterations (one per cycle, shared shift/add unit) and a scale by
//   57 registered with the last iteration, then are rounded and saturated.
//   One sample is in flight at a time; s_axis_tready is low while busy.
//   A new sample is taken only after the previous result has been taken.
//   m_axis holds its item until taken; a stalled receiver stalls intake.
//   Reset (rst, synchronous) clears the held angle to 0 and empties the core.
`default_nettype none
`include "assert_macros.svh"
module accel_tilt_roll_angle_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // roll_q8
  output logic             m_axis_tuser    // held
);
  import atr_pkg::*;

  atr_state_t state, state_next;
  logic signed [15:0] ax, ay, az;
  logic [SUMSQ_W-1:0] sumsq;
  logic [SUMSQ_W-1:0] sq_x, sq_z;
  logic               root_start, root_done;
  logic [ROOT_W-1:0]  root;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [STEP_W-1:0]  step;
  logic signed [ZW+7:0] scaled;
  logic signed [15:0] last_roll;
  logic signed [15:0] roll_q8;
  logic               held;
  logic               sq_phase;
  logic signed [ZW+7:0] rnd;
  logic signed [ZW+7-22:0] v;

  logic in_acc, out_acc, zero_in;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign zero_in = (s_axis_tdata == '0);

  // squares are registered; the root starts on their sum in the next cycle
  assign sumsq = sq_x + sq_z;

  atr_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(root_start), .sumsq(sumsq),
    .done(root_done), .root(root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = zero_in ? ST_OUT : ST_SQ;
      ST_SQ:     if (sq_phase) state_next = ST_ROOT;
      ST_ROOT:   if (root_done) state_next = ST_CORDIC;
      ST_CORDIC: if (step == STEP_W'(RUN_STEPS - 1)) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_OUT;
      ST_OUT:    if (out_acc) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    root_start    = (state == ST_SQ) && sq_phase;
  end
  assign m_axis_tdata = roll_q8;
  assign m_axis_tuser = held;

  // rounding of the scaled angle; saturation is applied in ST_SCALE
  assign rnd = scaled + (ZW+8)'(64'sd2097152);
  assign v   = rnd[ZW+7:22];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_roll <= '0;
      sq_phase  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            ax <= s_axis_tdata[15:0];
            ay <= s_axis_tdata[31:16];
            az <= s_axis_tdata[47:32];
            held <= zero_in;
            roll_q8 <= last_roll;
            sq_phase <= 1'b0;
          end
        end
        ST_SQ: begin
          if (!sq_phase) begin
            sq_x <= SUMSQ_W'(ax) * SUMSQ_W'(ax);
            sq_z <= SUMSQ_W'(az) * SUMSQ_W'(az);
            sq_phase <= 1'b1;
          end
        end
        ST_ROOT: begin
          cx   <= CW'(root);
          cy   <= CW'(ay) <<< 15;
          cz   <= '0;
          step <= '0;
        end
        ST_CORDIC: begin
          if (!cy[CW-1]) begin
            cx <= cx + (cy >>> step);
            cy <= cy - (cx >>> step);
            cz <= cz + $signed(atan_q30(step));
          end else begin
            cx <= cx - (cy >>> step);
            cy <= cy + (cx >>> step);
            cz <= cz - $signed(atan_q30(step));
          end
          step <= step + STEP_W'(1);
        end
        default: ;
      endcase
      if (state == ST_SCALE) begin
        if (v > (ZW+8-22)'(ROLL_LIMIT)) begin
          roll_q8 <= 16'(ROLL_LIMIT);
          last_roll <= 16'(ROLL_LIMIT);
        end else if (v < -(ZW+8-22)'(ROLL_LIMIT)) begin
          roll_q8 <= -16'(ROLL_LIMIT);
          last_roll <= -16'(ROLL_LIMIT);
        end else begin
          roll_q8 <= v[15:0];
          last_roll <= v[15:0];
        end
      end
    end
  end

  // scale product registered in the cycle before rounding; takes the last step
  always_ff @(posedge clk) begin
    if (state == ST_CORDIC && state_next == ST_SCALE) begin
      scaled <= (ZW+8)'(cz + ((!cy[CW-1]) ? $signed(atan_q30(step))
                                            : -$signed(atan_q30(step)))) * (ZW+8)'(ROLL_SCALE);
    end
  end

  `ASSERT_IMPL(a_out_range, clk, rst, m_axis_tvalid,
    ($signed(m_axis_tdata) <= 16'sd23040) && ($signed(m_axis_tdata) >= -16'sd23040),
    "roll out of range")
  `ASSERT_IMPL(a_one_side, clk, rst, s_axis_tready, !m_axis_tvalid,
    "intake open while result pending")
  `ASSERT_NEXT(a_held_repeat, clk, rst, in_acc && zero_in,
    m_axis_tvalid && m_axis_tuser && (m_axis_tdata == $past(last_roll)),
    "held sample did not repeat angle")
endmodule
`default_nettype wire
